// ===== sv/ccu_pkg.sv =====
package ccu_pkg;

  // field widths
  localparam int CLUSTER_W    = 10;
  localparam int VALUE_W      = 32;
  localparam int CNT_W        = 16;
  localparam int ACC_W        = 48;
  localparam int FRAC_W       = 16;

  // divider operand widths: numerator magnitude stays below 2^49
  localparam int NUM_W        = 49;
  localparam int DEN_W        = 48;
  localparam int DIV_CNT_W    = 6;

  // cluster index widened so that any table depth up to 65536 compares cleanly
  localparam int CLUSTER_EXT_W = 17;

  localparam int CLUSTERS_DEF = 1024;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_OBS   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [CLUSTER_W-1:0]      cluster;
    logic signed [VALUE_W-1:0] obs_value;
    logic signed [VALUE_W-1:0] target_sum;
    logic [CNT_W-1:0]          obs_count;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] coefficient;
    logic                      div_zero;
    logic                      saturated;
  } out_item_t;

endpackage

// ===== sv/cluster_coefficient_update.sv =====
// Flow: a load writes the memories; an observation reads the memory, then adds and writes back;
// a query reads the memories, then runs the 49-step shift and subtract divider (skipped with a
// zero divisor). One item is in work at a time; a query result waits while the output is full.
// Reset: mode returns to ratio and a clearing pass zeroes the accumulator memory, one entry a
// cycle, with in_ready low; configuration writes are taken throughout.
module cluster_coefficient_update #(
  parameter int CLUSTERS = ccu_pkg::CLUSTERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccu_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccu_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import ccu_pkg::*;

  localparam int IDX_W = $clog2(CLUSTERS);
  localparam int TC_W  = VALUE_W + CNT_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                     state_r;
  state_t                     state_nxt;
  logic [IDX_W-1:0]           clr_addr_r;
  logic [IDX_W-1:0]           clr_addr_nxt;
  logic                       mode_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  out_item_t                  out_data_r;
  out_item_t                  res_r;
  out_item_t                  res_nxt;
  logic                       out_load;

  logic [1:0]                 kind_r;
  logic [IDX_W-1:0]           addr_r;
  logic signed [VALUE_W-1:0]  obs_r;

  logic [ACC_W-1:0]           acc_mem [CLUSTERS];
  logic [TC_W-1:0]            tc_mem  [CLUSTERS];
  logic [ACC_W-1:0]           acc_rd_r;
  logic [TC_W-1:0]            tc_rd_r;
  logic                       acc_we;
  logic [IDX_W-1:0]           acc_waddr;
  logic [ACC_W-1:0]           acc_wdata;
  logic                       tc_we;

  logic                       in_fire;
  logic [CLUSTER_EXT_W-1:0]   cluster_ext;
  logic                       in_ok;
  logic [IDX_W-1:0]           in_addr;

  logic signed [VALUE_W-1:0]  tgt;
  logic signed [ACC_W-1:0]    acc;
  logic [CNT_W-1:0]           cnt;
  logic signed [NUM_W-1:0]    div_num;
  logic signed [DEN_W-1:0]    div_den;
  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  out_item_t                  div_res;

  // input decode
  assign in_fire     = in_valid && in_ready;
  assign cluster_ext = CLUSTER_EXT_W'(in_data.cluster);
  assign in_ok       = cluster_ext < CLUSTER_EXT_W'(CLUSTERS);
  assign in_addr     = cluster_ext[IDX_W-1:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // read data fields
  assign tgt = $signed(tc_rd_r[TC_W-1:CNT_W]);
  assign cnt = tc_rd_r[CNT_W-1:0];
  assign acc = $signed(acc_rd_r);

  // divider operands by mode
  always_comb begin
    if (!mode_r) begin
      div_num = {tgt[VALUE_W-1], tgt, {FRAC_W{1'b0}}};
      div_den = acc;
    end else begin
      div_num = {{(NUM_W - VALUE_W){tgt[VALUE_W-1]}}, tgt} - {acc[ACC_W-1], acc};
      div_den = {{(DEN_W - CNT_W){1'b0}}, cnt};
    end
  end

  // sequencer and memory write select
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    res_nxt      = res_r;
    acc_we       = 1'b0;
    acc_waddr    = addr_r;
    acc_wdata    = '0;
    tc_we        = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        acc_we       = 1'b1;
        acc_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(CLUSTERS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            KIND_LOAD: begin
              if (in_ok) begin
                acc_we    = 1'b1;
                acc_waddr = in_addr;
                tc_we     = 1'b1;
              end
            end
            KIND_OBS: begin
              if (in_ok) begin
                state_nxt = ST_EXEC;
              end
            end
            KIND_QUERY: begin
              if (in_ok) begin
                state_nxt = ST_EXEC;
              end else begin
                res_nxt   = '0;
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (kind_r == KIND_OBS) begin
          acc_we    = 1'b1;
          acc_wdata = acc_rd_r + {{(ACC_W - VALUE_W){obs_r[VALUE_W-1]}}, obs_r};
          state_nxt = ST_IDLE;
        end else if (div_den == '0) begin
          res_nxt.coefficient = '0;
          res_nxt.div_zero    = 1'b1;
          res_nxt.saturated   = 1'b0;
          state_nxt           = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_res;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      kind_r <= in_data.kind;
      addr_r <= in_addr;
      obs_r  <= in_data.obs_value;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // accumulator memory; one item at a time keeps each observation's read and write back apart from other items
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (in_fire) begin
      acc_rd_r <= acc_mem[in_addr];
    end
  end

  // target and count memory
  always_ff @(posedge clk) begin
    if (tc_we) begin
      tc_mem[in_addr] <= {in_data.target_sum, in_data.obs_count};
    end
    if (in_fire) begin
      tc_rd_r <= tc_mem[in_addr];
    end
  end

  ccu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("new item taken while divider runs");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.div_zero |-> out_data_r.coefficient == '0 &&
      !out_data_r.saturated)
    else $error("zero divisor result not cleared");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.saturated |->
      out_data_r.coefficient == 32'sh7FFF_FFFF || out_data_r.coefficient == 32'sh8000_0000)
    else $error("saturated result not at a range limit");

endmodule

// ===== sv/ccu_div.sv =====
module ccu_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ccu_pkg::NUM_W-1:0]  num,
  input  logic signed [ccu_pkg::DEN_W-1:0]  den,
  output logic                              busy,
  output logic                              done,
  output ccu_pkg::out_item_t                res
);
  import ccu_pkg::*;

  logic                   busy_r;
  logic                   busy_nxt;
  logic                   done_r;
  logic                   done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_CNT_W-1:0]   cnt_nxt;
  logic [NUM_W-1:0]       nq_r;
  logic [NUM_W-1:0]       nq_nxt;
  logic [DEN_W:0]         rem_r;
  logic [DEN_W:0]         rem_nxt;
  logic [DEN_W-1:0]       den_r;
  logic [DEN_W-1:0]       den_nxt;
  logic                   neg_r;
  logic                   neg_nxt;
  logic [NUM_W-1:0]       num_mag;
  logic [DEN_W-1:0]       den_mag;
  logic [DEN_W:0]         rem_sh;
  logic [DEN_W+1:0]       diff;
  logic                   sat;
  logic [NUM_W-1:0]       neg_q;

  // operand magnitudes
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  // one restoring step: shift in the next numerator bit, try the subtract
  assign rem_sh = {rem_r[DEN_W-1:0], nq_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      nq_nxt   = num_mag;
      rem_nxt  = '0;
      den_nxt  = den_mag;
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W:0];
        nq_nxt  = {nq_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        nq_nxt  = {nq_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign and clip the quotient magnitude
  assign neg_q = NUM_W'(-nq_r);
  always_comb begin
    if (neg_r) begin
      sat = nq_r > NUM_W'(64'h8000_0000);
      res.coefficient = sat ? 32'sh8000_0000 : $signed(neg_q[VALUE_W-1:0]);
    end else begin
      sat = nq_r > NUM_W'(64'h7FFF_FFFF);
      res.coefficient = sat ? 32'sh7FFF_FFFF : $signed(nq_r[VALUE_W-1:0]);
    end
    res.div_zero  = 1'b0;
    res.saturated = sat;
  end

  assign busy = busy_r;
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a running division");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

endmodule
